FILE: rtl/core/api_transmit_frame_builder_macros.svh
// Assertion macros for the transmit frame builder.
// Used by the top level only; no other dependencies.
`ifndef API_TRANSMIT_FRAME_BUILDER_MACROS_SVH
`define API_TRANSMIT_FRAME_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ATFB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame builder assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ATFB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame builder assertion failed");
`else
`define ATFB_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ATFB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/atfb_pkg.sv
// Shared types, codes and constants of the transmit frame builder.
// No dependencies; atfb_byte_sel and the top level import this package.
`timescale 1ns / 1ps

package atfb_pkg;

   localparam logic [7:0] START_DELIM = 8'h7E;
   localparam logic [7:0] FRAME_TYPE  = 8'h10;
   localparam logic [7:0] CSUM_BASE   = 8'hFF;
   localparam logic [8:0] LEN_BASE    = 9'd14;

   // Item function codes.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] REG_LONG_ADDR = 2'd0;
   localparam logic [1:0] REG_NET_ADDR  = 2'd1;
   localparam logic [1:0] REG_RADIUS    = 2'd2;
   localparam logic [1:0] REG_OPTIONS   = 2'd3;

   localparam int CSR_DATA_W = 64;

   // Byte positions within the results of one item.
   localparam logic [4:0] POS_DELIM      = 5'd0;
   localparam logic [4:0] POS_LEN_HI     = 5'd1;
   localparam logic [4:0] POS_LEN_LO     = 5'd2;
   localparam logic [4:0] POS_TYPE       = 5'd3;
   localparam logic [4:0] POS_FRAME_ID   = 5'd4;
   localparam logic [4:0] POS_LONG_FIRST = 5'd5;
   localparam logic [4:0] POS_LONG_LAST  = 5'd12;
   localparam logic [4:0] POS_NET_HI     = 5'd13;
   localparam logic [4:0] POS_NET_LO     = 5'd14;
   localparam logic [4:0] POS_RADIUS     = 5'd15;
   localparam logic [4:0] POS_OPTIONS    = 5'd16;
   localparam logic [4:0] POS_CSUM       = 5'd17;
   localparam logic [4:0] POS_DATA       = 5'd0;
   localparam logic [4:0] POS_DATA_CSUM  = 5'd1;

   typedef struct packed {
      logic       func;
      logic [7:0] frame_id;
      logic [7:0] payload_len;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [63:0] dest_long_addr;
      logic [15:0] dest_net_addr;
      logic [7:0]  hop_radius;
      logic [7:0]  tx_options;
   } cfg_type;

   // Sequencer state seen by the byte selector.
   typedef struct packed {
      logic [4:0] pos;
      logic [7:0] sum_acc;
      logic [7:0] bytes_left;
   } seq_type;

   // What the byte selector reports for the current position.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
      logic       add_sum;
   } sel_type;

endpackage

FILE: rtl/core/atfb_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing else.
`timescale 1ns / 1ps

interface atfb_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] frame_id;
   logic [7:0] payload_len;
   logic [7:0] data_byte;

   modport source (output valid, func, frame_id, payload_len, data_byte, input ready);
   modport sink   (input valid, func, frame_id, payload_len, data_byte, output ready);
endinterface

interface atfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       run_last;

   modport source (output valid, out_byte, frame_end, run_last, input ready);
   modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface

FILE: rtl/core/atfb_byte_sel.sv
// Picks the frame byte for the current position of an item and its flags.
// Depends on atfb_pkg.
`timescale 1ns / 1ps

module atfb_byte_sel
   import atfb_pkg::*;
(
   input  item_type item,
   input  cfg_type  cfg,
   input  seq_type  seq,
   output sel_type  sel
);

   logic [8:0] frame_len;
   logic [2:0] long_idx;

   assign frame_len = LEN_BASE + {1'b0, item.payload_len};
   // Position 5 carries the top byte of the long address, position 12 the bottom.
   assign long_idx  = 3'(POS_LONG_LAST - seq.pos);

   always_comb begin
      sel = '0;
      if (item.func == FUNC_START) begin
         sel.add_sum = 1'b1;
         case (seq.pos)
            POS_DELIM: begin
               sel.out_byte = START_DELIM;
               sel.add_sum  = 1'b0;
            end
            POS_LEN_HI: begin
               sel.out_byte = {7'd0, frame_len[8]};
               sel.add_sum  = 1'b0;
            end
            POS_LEN_LO: begin
               sel.out_byte = frame_len[7:0];
               sel.add_sum  = 1'b0;
            end
            POS_TYPE:     sel.out_byte = FRAME_TYPE;
            POS_FRAME_ID: sel.out_byte = item.frame_id;
            POS_NET_HI:   sel.out_byte = cfg.dest_net_addr[15:8];
            POS_NET_LO:   sel.out_byte = cfg.dest_net_addr[7:0];
            POS_RADIUS:   sel.out_byte = cfg.hop_radius;
            POS_OPTIONS: begin
               sel.out_byte = cfg.tx_options;
               sel.run_last = (item.payload_len != 8'd0);
            end
            POS_CSUM: begin
               sel.out_byte  = CSUM_BASE - seq.sum_acc;
               sel.frame_end = 1'b1;
               sel.run_last  = 1'b1;
               sel.add_sum   = 1'b0;
            end
            default: begin
               sel.out_byte = cfg.dest_long_addr[{long_idx, 3'b000} +: 8];
            end
         endcase
      end else begin
         case (seq.pos)
            POS_DATA: begin
               sel.out_byte = item.data_byte;
               sel.add_sum  = 1'b1;
               sel.run_last = (seq.bytes_left != 8'd1);
            end
            default: begin
               sel.out_byte  = CSUM_BASE - seq.sum_acc;
               sel.frame_end = 1'b1;
               sel.run_last  = 1'b1;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/api_transmit_frame_builder.sv
// Channel    | Dir | Handshake           | Carries
// req_ch     | in  | valid/ready         | func, frame_id, payload_len, data_byte
// rsp_ch     | out | valid/ready         | out_byte, frame_end, run_last
// csr_*      | in  | write enable only   | register index, 64-bit write data
//
// One result byte leaves per cycle; a stalled output holds the sequencer. A start
// item emits 17 bytes, or 18 with an empty payload; a payload item emits 1 byte,
// or 2 when its checksum follows. A payload item outside a frame is dropped
// without emitting a byte. The sequencer over the held item sets these figures.
// The next item is taken in the cycle the current one emits its last byte or is
// dropped. Synchronous reset clears all control state and loads register defaults.
// Depends on atfb_pkg, atfb_if and atfb_byte_sel.
`timescale 1ns / 1ps
`include "api_transmit_frame_builder_macros.svh"

module api_transmit_frame_builder
   import atfb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   atfb_req_if.sink              req_ch,
   atfb_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_vld_ff;
   logic [4:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] left_ff, left_in;
   logic       open_ff, open_in;
   logic       rsp_vld_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff;
   logic       rsp_last_ff;

   seq_type    seq;
   sel_type    sel;
   logic       step;
   logic       drop;
   logic       emit;
   logic       item_done;

   assign seq.pos        = pos_ff;
   assign seq.sum_acc    = sum_ff;
   assign seq.bytes_left = left_ff;

   atfb_byte_sel u_sel (
      .item (item_ff),
      .cfg  (cfg_ff),
      .seq  (seq),
      .sel  (sel)
   );

   // The sequencer advances whenever the output register is free or being drained.
   assign step      = item_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign drop      = (item_ff.func == FUNC_DATA) && !open_ff;
   assign emit      = step && !drop;
   assign item_done = step && (drop || sel.run_last);

   assign req_ch.ready     = !item_vld_ff || item_done;
   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.out_byte  = rsp_byte_ff;
   assign rsp_ch.frame_end = rsp_end_ff;
   assign rsp_ch.run_last  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_long_addr <= 64'd0;
         cfg_ff.dest_net_addr  <= 16'hFFFE;
         cfg_ff.hop_radius     <= 8'd0;
         cfg_ff.tx_options     <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LONG_ADDR: cfg_ff.dest_long_addr <= csr_wdata;
            REG_NET_ADDR:  cfg_ff.dest_net_addr  <= csr_wdata[15:0];
            REG_RADIUS:    cfg_ff.hop_radius     <= csr_wdata[7:0];
            REG_OPTIONS:   cfg_ff.tx_options     <= csr_wdata[7:0];
            default:       cfg_ff.tx_options     <= cfg_ff.tx_options;
         endcase
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      left_in = left_ff;
      open_in = open_ff;
      if (emit) begin
         pos_in = sel.run_last ? 5'd0 : pos_ff + 5'd1;
         if (item_ff.func == FUNC_START && pos_ff == POS_DELIM) begin
            sum_in = 8'd0;
         end else if (sel.add_sum) begin
            sum_in = sum_ff + sel.out_byte;
         end
         if (item_ff.func == FUNC_START && pos_ff == POS_OPTIONS) begin
            open_in = 1'b1;
            left_in = item_ff.payload_len;
         end
         if (item_ff.func == FUNC_DATA && pos_ff == POS_DATA) begin
            left_in = left_ff - 8'd1;
         end
         if (sel.frame_end) begin
            open_in = 1'b0;
            left_in = 8'd0;
            sum_in  = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         pos_ff      <= 5'd0;
         sum_ff      <= 8'd0;
         left_ff     <= 8'd0;
         open_ff     <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         left_ff <= left_in;
         open_ff <= open_in;
         if (req_ch.valid && req_ch.ready) begin
            item_vld_ff <= 1'b1;
         end else if (item_done) begin
            item_vld_ff <= 1'b0;
         end
         if (emit) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.func        <= req_ch.func;
         item_ff.frame_id    <= req_ch.frame_id;
         item_ff.payload_len <= req_ch.payload_len;
         item_ff.data_byte   <= req_ch.data_byte;
      end
      if (emit) begin
         rsp_byte_ff <= sel.out_byte;
         rsp_end_ff  <= sel.frame_end;
         rsp_last_ff <= sel.run_last;
      end
   end

   // A checksum byte always closes the work of its item.
   `ATFB_ASSERT_NOW(a_end_is_last, clock, reset, rsp_vld_ff && rsp_end_ff, rsp_last_ff)
   // Between items, an open frame always still expects at least one payload byte.
   `ATFB_ASSERT_NOW(a_open_has_left, clock, reset, open_ff && !item_vld_ff, left_ff != 8'd0)
   // The sequencer never runs past the checksum position.
   `ATFB_ASSERT_NOW(a_pos_range, clock, reset, item_vld_ff, pos_ff <= POS_CSUM)
   // An accepted item is held for the sequencer in the next cycle.
   `ATFB_ASSERT_NXT(a_item_held, clock, reset, req_ch.valid && req_ch.ready, item_vld_ff)

endmodule
